// ===== hw/rtl/next_fit_id_bitmap_allocator_macros.svh =====
// assertion macros used by the allocator rtl
`ifndef NEXT_FIT_ID_BITMAP_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_ID_BITMAP_ALLOCATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NFID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define NFID_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition must never hold
`define NFID_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ===== hw/rtl/nfid_pkg.sv =====
// shared types and codes of the next-fit id allocator
`default_nettype none

package nfid_pkg;

	// width of the id fields on the ports
	localparam int ID_W = 10;

	// request opcodes
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_FREE     = 2'd1,
		ST_BAD_RELEASE = 2'd2
	} status_t;

	// control sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC,
		S_REL_DIV,
		S_REL_UPD
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nfid_mem.sv =====
// bitmap word memory: one write port, two registered read ports
`default_nettype none

module nfid_mem #(
	parameter int NWORDS    = 32,
	parameter int WORD_BITS = 32,
	parameter int WA        = 5
) (
	input  wire logic                 clk,
	input  wire logic                 re,
	input  wire logic [WA-1:0]        raddr_a,
	input  wire logic [WA-1:0]        raddr_b,
	output logic      [WORD_BITS-1:0] rdata_a,
	output logic      [WORD_BITS-1:0] rdata_b,
	input  wire logic                 we,
	input  wire logic [WA-1:0]        waddr,
	input  wire logic [WORD_BITS-1:0] wdata
);

	logic [WORD_BITS-1:0] mem_q [NWORDS];
	logic [WORD_BITS-1:0] rd_a_q;
	logic [WORD_BITS-1:0] rd_b_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read ports with registered data
	always_ff @(posedge clk) begin
		if (re) begin
			rd_a_q <= mem_q[raddr_a];
			rd_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nfid_div.sv =====
// id to word and bit split by reciprocal multiply, one register stage
`default_nettype none

module nfid_div #(
	parameter int ID_COUNT  = 1024,
	parameter int WORD_BITS = 32,
	parameter int IW        = 10,
	parameter int WA        = 5,
	parameter int BW        = 5
) (
	input  wire logic          clk,
	input  wire logic          load,
	input  wire logic [IW-1:0] id,
	output logic      [WA-1:0] word_idx,
	output logic      [BW-1:0] bit_idx
);

	// floor(2^IW / WORD_BITS); quotient estimate is exact or one low
	localparam int RECIP = (2 ** IW) / WORD_BITS;
	localparam int PW    = IW + BW + 1;

	logic [2*IW-1:0] prod;
	logic [IW-1:0]   q0_s1;
	logic [IW-1:0]   id_s1;
	logic [PW-1:0]   qw;
	logic [PW-1:0]   diff;
	logic [BW:0]     rem0;

	// quotient estimate
	assign prod = (2*IW)'(id) * (2*IW)'(RECIP);

	always_ff @(posedge clk) begin
		if (load) begin
			q0_s1 <= prod[2*IW-1:IW];
			id_s1 <= id;
		end
	end

	// remainder and one correction step
	assign qw   = PW'(q0_s1) * PW'(WORD_BITS);
	assign diff = PW'(id_s1) - qw;
	assign rem0 = diff[BW:0];

	always_comb begin
		if (rem0 >= (BW+1)'(WORD_BITS)) begin
			word_idx = WA'(q0_s1 + 1'b1);
			bit_idx  = BW'(rem0 - (BW+1)'(WORD_BITS));
		end else begin
			word_idx = WA'(q0_s1);
			bit_idx  = BW'(rem0);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/nfid_flags.sv =====
// per-word full flags and circular search for the next word with a free id
`default_nettype none

module nfid_flags #(
	parameter int NWORDS = 32,
	parameter int WA     = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [WA-1:0] start_word,
	output logic               any_free,
	output logic      [WA-1:0] next_word,
	input  wire logic          upd_en,
	input  wire logic [WA-1:0] upd_idx,
	input  wire logic          upd_full
);

	logic [NWORDS-1:0] full_q;
	logic [NWORDS-1:0] not_full;
	logic [NWORDS-1:0] above;
	logic [WA-1:0]     low_above;
	logic [WA-1:0]     low_any;

	// flag per word, set when every grantable id of the word is used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (upd_en) begin
			full_q[upd_idx] <= upd_full;
		end
	end

	assign not_full = ~full_q;

	// words after the start word, then wrap around to the start word itself
	always_comb begin
		above     = '0;
		low_above = '0;
		low_any   = '0;
		for (int p = 0; p < NWORDS; p++) begin
			above[p] = not_full[p] && (WA'(p) > start_word);
		end
		for (int p = NWORDS - 1; p >= 0; p--) begin
			if (above[p]) begin
				low_above = WA'(p);
			end
			if (not_full[p]) begin
				low_any = WA'(p);
			end
		end
	end

	assign any_free  = |not_full;
	assign next_word = (|above) ? low_above : low_any;

endmodule

`default_nettype wire

// ===== hw/rtl/next_fit_id_bitmap_allocator.sv =====
// Next-fit unique id allocator over a bitmap held in a word memory.
//
// Input channel (in_valid/in_ready): op selects allocate or release; release_id
// names the id to give back and is ignored on allocate.
// Output channel (out_valid/out_ready): one transfer per request carrying
// granted_id and status (ok, no free id, bad release).
// On allocate, the accept edge reads the start word and the next non-full word
// (picked from a per-word full-flag vector), then S_ALLOC picks the bit and
// writes the word back.
// On release, a reciprocal multiply splits the id into word and bit, then the
// word is read in S_REL_DIV and written back in S_REL_UPD.
// One request is in flight at a time; the bitmap memory read-modify-write
// sets the pace. A new request is taken while the previous result still waits
// in the output register; when the receiver stalls, the write-back waits until
// the output register frees up.
// After reset the block runs a clearing pass that zeros the NWORDS bitmap
// words (32 with the default parameters); in_ready stays low meanwhile.
`default_nettype none
`include "next_fit_id_bitmap_allocator_macros.svh"

module next_fit_id_bitmap_allocator
	import nfid_pkg::*;
#(
	parameter int ID_COUNT  = 1024,
	parameter int WORD_BITS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            op,
	input  wire logic [ID_W-1:0] release_id,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic      [ID_W-1:0] granted_id,
	output logic      [1:0]      status
);

	localparam int NWORDS    = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WA        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int IW        = $clog2(ID_COUNT);
	localparam int XW        = (IW > ID_W) ? IW : ID_W;
	localparam int LAST_BITS = ID_COUNT - (NWORDS - 1) * WORD_BITS;
	localparam logic [WORD_BITS-1:0] LAST_MASK =
		{WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

	// bits of a word that hold grantable ids
	function automatic logic [WORD_BITS-1:0] grant_mask(input logic [WA-1:0] w);
		logic [WORD_BITS-1:0] m;
		m = {WORD_BITS{1'b1}};
		if (w == WA'(NWORDS - 1)) begin
			m = m & LAST_MASK;
		end
		if (w == '0) begin
			m[0] = 1'b0;
		end
		return m;
	endfunction

	// index of the lowest set bit
	function automatic logic [BW-1:0] low_bit(input logic [WORD_BITS-1:0] v);
		logic [BW-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = BW'(i);
			end
		end
		return idx;
	endfunction

	state_t state_q, state_d;

	logic [WA-1:0]        clr_q;
	logic [WA-1:0]        lw_q;
	logic [BW-1:0]        lb_q;
	logic                 out_valid_q;
	logic [ID_W-1:0]      granted_q;
	status_t              status_q;

	logic [WA-1:0]        sw_s1;
	logic [BW-1:0]        sb_s1;
	logic [WA-1:0]        w2_s1;
	logic                 any_s1;
	logic                 rel_bad_s1;
	logic [WA-1:0]        rel_word_s2;
	logic [BW-1:0]        rel_bit_s2;
	logic                 rel_bad_s2;

	logic                 accept;
	logic                 out_free;
	logic                 bit_wrap;
	logic [WA:0]          nw_x;
	logic [BW-1:0]        nb;
	logic                 start_wrap;
	logic [WA-1:0]        sw;
	logic [BW-1:0]        sb;
	logic                 any_free;
	logic [WA-1:0]        next_word;
	logic [XW-1:0]        rel_x;
	logic                 rel_bad;
	logic [WA-1:0]        div_word;
	logic [BW-1:0]        div_bit;
	logic [WA-1:0]        rel_addr;

	logic                 mem_re;
	logic [WA-1:0]        mem_ra;
	logic [WORD_BITS-1:0] rd_a;
	logic [WORD_BITS-1:0] rd_b;
	logic                 mem_we;
	logic [WA-1:0]        mem_wa;
	logic [WORD_BITS-1:0] mem_wd;

	logic [WORD_BITS-1:0] free_a;
	logic [WORD_BITS-1:0] free_b;
	logic                 alloc_found;
	logic [WA-1:0]        sel_w;
	logic [BW-1:0]        sel_b;
	logic [WORD_BITS-1:0] sel_data;
	logic [WORD_BITS-1:0] bit_oh;
	logic [WORD_BITS-1:0] new_word;
	logic [IW-1:0]        gid;
	logic [WORD_BITS-1:0] rel_oh;
	logic                 rel_hit;

	logic                 upd_en;
	logic [WA-1:0]        upd_idx;
	logic                 upd_full;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// start point: id after the last grant, wrapping to id one
	assign bit_wrap   = (lb_q == BW'(WORD_BITS - 1));
	assign nw_x       = bit_wrap ? ({1'b0, lw_q} + 1'b1) : {1'b0, lw_q};
	assign nb         = bit_wrap ? '0 : (lb_q + 1'b1);
	assign start_wrap = (nw_x == (WA+1)'(NWORDS)) ||
		((nw_x == (WA+1)'(NWORDS - 1)) && ({1'b0, nb} >= (BW+1)'(LAST_BITS)));
	assign sw = start_wrap ? '0 : nw_x[WA-1:0];
	assign sb = start_wrap ? BW'(1) : nb;

	// release range check
	assign rel_x   = XW'(release_id);
	assign rel_bad = (release_id == '0) || (32'(rel_x) >= 32'(ID_COUNT));

	nfid_flags #(
		.NWORDS (NWORDS),
		.WA     (WA)
	) u_flags (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_word (sw),
		.any_free   (any_free),
		.next_word  (next_word),
		.upd_en     (upd_en),
		.upd_idx    (upd_idx),
		.upd_full   (upd_full)
	);

	nfid_div #(
		.ID_COUNT  (ID_COUNT),
		.WORD_BITS (WORD_BITS),
		.IW        (IW),
		.WA        (WA),
		.BW        (BW)
	) u_div (
		.clk      (clk),
		.load     (accept && (op == OP_RELEASE)),
		.id       (IW'(rel_x)),
		.word_idx (div_word),
		.bit_idx  (div_bit)
	);

	assign rel_addr = rel_bad_s1 ? '0 : div_word;

	nfid_mem #(
		.NWORDS    (NWORDS),
		.WORD_BITS (WORD_BITS),
		.WA        (WA)
	) u_mem (
		.clk     (clk),
		.re      (mem_re),
		.raddr_a (mem_ra),
		.raddr_b (next_word),
		.rdata_a (rd_a),
		.rdata_b (rd_b),
		.we      (mem_we),
		.waddr   (mem_wa),
		.wdata   (mem_wd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == WA'(NWORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = (op == OP_RELEASE) ? S_REL_DIV : S_ALLOC;
				end
			end
			S_ALLOC: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_REL_DIV: begin
				state_d = S_REL_UPD;
			end
			S_REL_UPD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		mem_re   = 1'b0;
		mem_ra   = sw;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				mem_re   = in_valid && (op == OP_ALLOC);
			end
			S_REL_DIV: begin
				mem_re = 1'b1;
				mem_ra = rel_addr;
			end
			S_CLEAR, S_ALLOC, S_REL_UPD: begin
				mem_re = 1'b0;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// allocate: lowest free bit at or above the start, else in the next non-full word
	assign free_a = ~rd_a & grant_mask(sw_s1) & ({WORD_BITS{1'b1}} << sb_s1);
	assign free_b = ~rd_b & grant_mask(w2_s1);

	always_comb begin
		alloc_found = 1'b0;
		sel_w       = sw_s1;
		sel_data    = rd_a;
		sel_b       = low_bit(free_a);
		if (|free_a) begin
			alloc_found = 1'b1;
		end else if (any_s1) begin
			alloc_found = 1'b1;
			sel_w       = w2_s1;
			sel_data    = rd_b;
			sel_b       = low_bit(free_b);
		end
	end

	assign bit_oh   = WORD_BITS'(1) << sel_b;
	assign new_word = sel_data | bit_oh;
	assign gid      = IW'(IW'(sel_w) * IW'(WORD_BITS)) + IW'(sel_b);

	// release: the bit must be set
	assign rel_oh  = WORD_BITS'(1) << rel_bit_s2;
	assign rel_hit = !rel_bad_s2 && rd_a[rel_bit_s2];

	// memory write and full-flag update
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = sel_w;
		mem_wd   = new_word;
		upd_en   = 1'b0;
		upd_idx  = sel_w;
		upd_full = &(new_word | ~grant_mask(sel_w));
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			S_ALLOC: begin
				mem_we = alloc_found && out_free;
				upd_en = alloc_found && out_free;
			end
			S_REL_UPD: begin
				mem_we   = rel_hit && out_free;
				mem_wa   = rel_word_s2;
				mem_wd   = rd_a & ~rel_oh;
				upd_en   = rel_hit && out_free;
				upd_idx  = rel_word_s2;
				upd_full = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			lw_q        <= '0;
			lb_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if ((state_q == S_ALLOC) && alloc_found && out_free) begin
				lw_q <= sel_w;
				lb_q <= sel_b;
			end
			if (((state_q == S_ALLOC) || (state_q == S_REL_UPD)) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request stage registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sw_s1      <= sw;
			sb_s1      <= sb;
			w2_s1      <= next_word;
			any_s1     <= any_free;
			rel_bad_s1 <= rel_bad;
		end
		if (state_q == S_REL_DIV) begin
			rel_word_s2 <= rel_addr;
			rel_bit_s2  <= div_bit;
			rel_bad_s2  <= rel_bad_s1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if ((state_q == S_ALLOC) && out_free) begin
			granted_q <= alloc_found ? ID_W'(gid) : '0;
			status_q  <= alloc_found ? ST_OK : ST_NO_FREE;
		end else if ((state_q == S_REL_UPD) && out_free) begin
			granted_q <= '0;
			status_q  <= rel_hit ? ST_OK : ST_BAD_RELEASE;
		end
	end

	assign out_valid  = out_valid_q;
	assign granted_id = granted_q;
	assign status     = status_q;

	`NFID_ASSERT_NXT(a_accept_starts, clk, arst_n, in_valid && in_ready, state_q == S_ALLOC || state_q == S_REL_DIV, "accepted request did not start work")
	`NFID_ASSERT_IMP(a_fail_no_id, clk, arst_n, out_valid_q && (status_q != ST_OK), granted_q == '0, "failed request carries an id")
	`NFID_ASSERT_IMP(a_grant_was_free, clk, arst_n, (state_q == S_ALLOC) && alloc_found, (sel_data & bit_oh) == '0, "granted id already in use")
	`NFID_ASSERT_IMP(a_grant_nonzero, clk, arst_n, (state_q == S_ALLOC) && alloc_found, gid != '0, "id zero granted")
	`NFID_ASSERT_NEVER(a_no_stray_write, clk, arst_n, mem_we && (state_q == S_IDLE || state_q == S_REL_DIV), "bitmap written outside an update")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench of the next-fit id bitmap allocator
module testbench;
	import nfid_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ID_COUNT = 1024;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;

	// one request on the input channel
	typedef struct {
		logic            op;
		logic [ID_W-1:0] id;
		int              gap;
		bit              drain;
	} request_t;

	// one answer on the output channel
	typedef struct {
		logic [ID_W-1:0] gid;
		status_t         st;
	} answer_t;

	// allocator state: one used flag per id and the last id granted
	typedef struct {
		bit [ID_COUNT-1:0] taken;
		logic [ID_W-1:0]   last;
	} pool_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	logic            op = OP_ALLOC;
	logic [ID_W-1:0] release_id = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	logic [ID_W-1:0] granted_id;
	logic [1:0]      status;

	request_t request_q[$];
	answer_t  due_answers[$];
	pool_t    live_pool;
	pool_t    plan_pool;
	logic [ID_W-1:0] plan_live[$];

	bit in_took = 1'b0;
	bit out_took = 1'b0;
	bit long_hold = 1'b0;
	bit send_quiet = 1'b0;
	bit recv_quiet = 1'b0;
	int send_wait = 0;
	int recv_wait = 0;
	int accepted_cnt = 0;
	int answer_cnt = 0;
	int idle_cycles = 0;
	int error_cnt = 0;

	next_fit_id_bitmap_allocator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.release_id (release_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.granted_id (granted_id),
		.status     (status)
	);

	// clock and reset
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
	end

	// next-fit allocate or checked release on a pool
	function automatic void next_fit_step(inout pool_t p, input logic rq_op,
	                                      input logic [ID_W-1:0] rq_id,
	                                      output logic [ID_W-1:0] gid, output status_t st);
		int first;
		int cand;
		int k;
		bit found;
		gid = '0;
		st = ST_OK;
		if (rq_op == OP_ALLOC) begin
			// circular scan over ids from the one after the last grant, id zero excluded
			first = (int'(p.last) + 1 < ID_COUNT) ? int'(p.last) + 1 : 1;
			found = 1'b0;
			k = 0;
			while (!found && k < ID_COUNT) begin
				cand = (first + k) % ID_COUNT;
				if (cand != 0 && !p.taken[cand])
					found = 1'b1;
				else
					k++;
			end
			if (found) begin
				p.taken[cand] = 1'b1;
				p.last = cand[ID_W-1:0];
				gid = cand[ID_W-1:0];
			end else begin
				st = ST_NO_FREE;
			end
		end else begin
			if (rq_id == '0 || int'(rq_id) >= ID_COUNT || !p.taken[rq_id])
				st = ST_BAD_RELEASE;
			else
				p.taken[rq_id] = 1'b0;
		end
	endfunction

	task automatic report_error(input string msg);
		if (error_cnt < 100)
			$display("ERROR: %s", msg);
		error_cnt++;
	endtask

	// queue one request, tracking which ids the plan leaves allocated
	task automatic add_request(input logic rq_op, input logic [ID_W-1:0] rq_id,
	                           input bit drain);
		request_t r;
		logic [ID_W-1:0] gid;
		status_t st;
		if ($urandom_range(0, 39) == 0)
			send_quiet = !send_quiet;
		r.op = rq_op;
		r.id = rq_id;
		r.gap = send_quiet ? 0 : $urandom_range(0, 6);
		r.drain = drain || ($urandom_range(0, 79) == 0);
		next_fit_step(plan_pool, rq_op, rq_id, gid, st);
		if (rq_op == OP_ALLOC && st == ST_OK)
			plan_live.push_back(gid);
		if (rq_op == OP_RELEASE && st == ST_OK) begin
			foreach (plan_live[i])
				if (plan_live[i] == rq_id) begin
					plan_live.delete(i);
					break;
				end
		end
		request_q.push_back(r);
	endtask

	// release a random id that the plan holds, or allocate if none is held
	task automatic add_live_release();
		if (plan_live.size() != 0)
			add_request(OP_RELEASE, plan_live[$urandom_range(0, plan_live.size() - 1)], 1'b0);
		else
			add_request(OP_ALLOC, ID_W'($urandom), 1'b0);
	endtask

	// stimulus and end of run
	initial begin
		int r;
		int total;
		plan_pool.taken = '0;
		plan_pool.last = '0;
		live_pool = plan_pool;

		// directed: bad releases, first grants, release and reuse
		add_request(OP_RELEASE, '0, 1'b0);
		add_request(OP_RELEASE, '1, 1'b0);
		add_request(OP_RELEASE, 10'd5, 1'b0);
		add_request(OP_ALLOC, '1, 1'b0);
		add_request(OP_ALLOC, '0, 1'b0);
		add_request(OP_ALLOC, 10'h2aa, 1'b0);
		add_request(OP_RELEASE, 10'd2, 1'b0);
		add_request(OP_RELEASE, 10'd2, 1'b0);
		add_request(OP_ALLOC, 10'h155, 1'b0);
		add_request(OP_RELEASE, 10'd1, 1'b1);
		add_request(OP_RELEASE, '1, 1'b0);
		add_request(OP_ALLOC, '1, 1'b0);
		add_request(OP_RELEASE, 10'd3, 1'b0);
		add_request(OP_ALLOC, '0, 1'b0);

		// mixed traffic, mostly well-formed
		for (int i = 0; i < 400; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				add_request(OP_ALLOC, ID_W'($urandom), 1'b0);
			else if (r < 85)
				add_live_release();
			else
				add_request(OP_RELEASE, ID_W'($urandom), 1'b0);
		end

		// fill the pool through wraparound to exhaustion
		add_request(OP_ALLOC, ID_W'($urandom), 1'b1);
		while (plan_live.size() < ID_COUNT - 1)
			add_request(OP_ALLOC, ID_W'($urandom), 1'b0);
		for (int i = 0; i < 4; i++)
			add_request(OP_ALLOC, ID_W'($urandom), 1'b0);
		for (int i = 0; i < 3; i++) begin
			add_live_release();
			add_request(OP_ALLOC, ID_W'($urandom), 1'b0);
		end
		add_request(OP_ALLOC, ID_W'($urandom), 1'b0);
		add_request(OP_RELEASE, '0, 1'b0);

		// drain mostly by releases
		add_live_release();
		for (int i = 0; i < 300; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				add_live_release();
			else if (r < 85)
				add_request(OP_ALLOC, ID_W'($urandom), 1'b0);
			else
				add_request(OP_RELEASE, ID_W'($urandom), 1'b0);
		end

		// wait until every request is taken and every result has come back
		total = request_q.size();
		while (accepted_cnt < total || due_answers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_cnt == 0)
			$display("** next_fit_id_bitmap_allocator: PASSED **");
		else
			$display("** next_fit_id_bitmap_allocator: FAILED **");
		$finish;
	end

	// long receiver stall so the block backs up into its input
	initial begin
		while (accepted_cnt < 250)
			@(posedge clk);
		long_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold = 1'b0;
	end

	// request driver
	always @(negedge clk) begin : drive
		logic nv;
		request_t cur;
		if (arst_n && (!in_valid || in_took)) begin
			nv = 1'b0;
			if (send_wait != 0) begin
				send_wait--;
			end else if (request_q.size() != 0 &&
			             (!request_q[0].drain || due_answers.size() == 0)) begin
				cur = request_q.pop_front();
				op <= cur.op;
				release_id <= cur.id;
				nv = 1'b1;
				send_wait = (request_q.size() != 0) ? request_q[0].gap : 0;
			end
			in_valid <= nv;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took) begin
				if ($urandom_range(0, 39) == 0)
					recv_quiet = !recv_quiet;
				recv_wait = recv_quiet ? 0 : $urandom_range(0, 6);
			end
			if (long_hold) begin
				out_ready <= 1'b0;
			end else if (recv_wait != 0) begin
				out_ready <= 1'b0;
				recv_wait--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: check each result transfer, predict each request transfer
	always @(posedge clk) begin : watch
		answer_t want;
		logic [ID_W-1:0] gid;
		status_t st;
		in_took = arst_n && in_valid && in_ready;
		out_took = arst_n && out_valid && out_ready;
		if (out_took) begin
			if (due_answers.size() == 0) begin
				report_error($sformatf("result %0d arrived with none outstanding: id %0d status %0d",
				                       answer_cnt, granted_id, status));
			end else begin
				want = due_answers.pop_front();
				if (granted_id !== want.gid)
					report_error($sformatf("result %0d granted_id %0d, expected %0d",
					                       answer_cnt, granted_id, want.gid));
				if (status !== want.st)
					report_error($sformatf("result %0d status %0d, expected %0d",
					                       answer_cnt, status, want.st));
			end
			answer_cnt++;
		end
		if (in_took) begin
			next_fit_step(live_pool, op, release_id, gid, st);
			want.gid = gid;
			want.st = st;
			due_answers.push_back(want);
			accepted_cnt++;
		end
		// watchdog on cycles without any transfer
		if (in_took || out_took) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", idle_cycles);
				$display("** next_fit_id_bitmap_allocator: FAILED **");
				$finish;
			end
		end
	end

endmodule
